[rtl/lrat_pkg.sv]
// ----------------------------------------------------------------------------
// lrat_pkg
// Shared types, constants and saturating arithmetic for the lazy
// range-add / range-max tree.
// ----------------------------------------------------------------------------
package lrat_pkg;

    typedef struct packed {
        logic signed [63:0] node_max;
        logic signed [63:0] pend;
    } t_entry;

    localparam logic signed [63:0] IDENT   = -64'sd1000000000000000000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] NONE    = -64'sd1;

    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_MAX    = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? S64_MIN : S64_MAX;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] smax(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        smax = (a > b) ? a : b;
    endfunction

    function automatic t_entry give(input t_entry e, input logic signed [63:0] v,
                                    input logic internal);
        t_entry r;
        r.node_max = sat_add(e.node_max, v);
        r.pend     = internal ? sat_add(e.pend, v) : e.pend;
        give = r;
    endfunction

endpackage

[rtl/lrat_mem.sv]
// ----------------------------------------------------------------------------
// lrat_mem
// Node memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrat_mem #(
    parameter int AW = 11
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  lrat_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output lrat_pkg::t_entry   o_rdata
);

    lrat_pkg::t_entry mem [0:(1 << AW) - 1];
    lrat_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lrat_seq.sv]
// ----------------------------------------------------------------------------
// lrat_seq
// Tree walk sequencer: clearing pass, depth-first visit with lazy tag push,
// parent rebuild and rightmost nonnegative search.
// ----------------------------------------------------------------------------
module lrat_seq #(
    parameter int LEAVES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic [9:0]                    i_range_low,
    input  logic [10:0]                   i_range_high,
    input  logic signed [63:0]            i_operand_value,
    output logic                          o_res_valid,
    output logic signed [63:0]            o_res,
    input  logic                          i_res_ready,
    output logic                          o_we,
    output logic [$clog2(LEAVES):0]       o_waddr,
    output lrat_pkg::t_entry              o_wdata,
    output logic [$clog2(LEAVES):0]       o_raddr,
    input  lrat_pkg::t_entry              i_rdata
);

    localparam int LG = $clog2(LEAVES);
    localparam int AW = LG + 1;
    localparam int BW = LG + 1;
    localparam logic [BW-1:0] SPAN = BW'(1) << LG;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_VISIT = 4'd2;
    localparam logic [3:0] ST_EVAL  = 4'd3;
    localparam logic [3:0] ST_PB    = 4'd4;
    localparam logic [3:0] ST_PC    = 4'd5;
    localparam logic [3:0] ST_PD    = 4'd6;
    localparam logic [3:0] ST_DESC  = 4'd7;
    localparam logic [3:0] ST_SRCH  = 4'd8;
    localparam logic [3:0] ST_RET   = 4'd9;
    localparam logic [3:0] ST_RB1   = 4'd10;
    localparam logic [3:0] ST_RB2   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    logic [3:0]         r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [1:0]         r_kind, n_kind;
    logic [BW-1:0]      r_lo, n_lo, r_hi, n_hi;
    logic signed [63:0] r_v, n_v;
    logic [AW-1:0]      r_node, n_node;
    logic [BW-1:0]      r_nlo, n_nlo, r_sz, n_sz;
    logic signed [63:0] r_tag, n_tag, r_self, n_self, r_left, n_left;
    logic signed [63:0] r_acc, n_acc, r_res, n_res;

    logic [31:0]        lo32, hi32, lo_c, hi_c;
    logic [BW-1:0]      nhi, half;
    logic               disjoint, covered, is_leaf, kids_int;
    logic [AW-1:0]      left_c, right_c;
    lrat_pkg::t_entry   clr_e, self_e, rb_e;

    always_comb begin
        lo32     = 32'(i_range_low);
        hi32     = 32'(i_range_high);
        lo_c     = (lo32 > 32'(LEAVES)) ? 32'(LEAVES) : lo32;
        hi_c     = (hi32 > 32'(LEAVES)) ? 32'(LEAVES) : hi32;
        nhi      = r_nlo + r_sz;
        half     = r_sz >> 1;
        disjoint = (r_hi <= r_nlo) || (nhi <= r_lo);
        covered  = (r_lo <= r_nlo) && (nhi <= r_hi);
        is_leaf  = (r_sz == BW'(1));
        kids_int = (r_sz > BW'(2));
        left_c   = {r_node[AW-2:0], 1'b0};
        right_c  = {r_node[AW-2:0], 1'b1};
        clr_e.node_max = lrat_pkg::IDENT;
        clr_e.pend     = 64'sd0;
        self_e.node_max = r_self;
        self_e.pend     = 64'sd0;
        rb_e.node_max  = lrat_pkg::smax(r_left, i_rdata.node_max);
        rb_e.pend      = 64'sd0;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_v     = r_v;
        n_node  = r_node;
        n_nlo   = r_nlo;
        n_sz    = r_sz;
        n_tag   = r_tag;
        n_self  = r_self;
        n_left  = r_left;
        n_acc   = r_acc;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_node;
        o_wdata = i_rdata;
        o_raddr = r_node;
        case (r_state)
            ST_CLR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt;
                o_wdata = clr_e;
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_kind = i_kind;
                    n_lo   = BW'(lo_c);
                    n_hi   = BW'(hi_c);
                    n_v    = i_operand_value;
                    n_node = AW'(1);
                    n_nlo  = '0;
                    n_sz   = SPAN;
                    n_acc  = lrat_pkg::IDENT;
                    case (i_kind)
                        lrat_pkg::KIND_SET: begin
                            if (lo_c < 32'(LEAVES)) n_state = ST_VISIT;
                        end
                        lrat_pkg::KIND_ADD: begin
                            if (lo_c < hi_c) n_state = ST_VISIT;
                        end
                        lrat_pkg::KIND_MAX: begin
                            if (lo_c < hi_c) begin
                                n_state = ST_VISIT;
                            end else begin
                                n_res   = lrat_pkg::IDENT;
                                n_state = ST_OUT;
                            end
                        end
                        default: n_state = ST_VISIT;
                    endcase
                end
            end
            ST_VISIT: begin
                o_raddr = r_node;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_tag  = i_rdata.pend;
                n_self = i_rdata.node_max;
                n_state = (i_rdata.pend == 64'sd0) ? ST_DESC : ST_PB;
                o_raddr = left_c;
                case (r_kind)
                    lrat_pkg::KIND_SET: begin
                        if (is_leaf) begin
                            o_we             = 1'b1;
                            o_waddr          = r_node;
                            o_wdata.node_max = r_v;
                            o_wdata.pend     = i_rdata.pend;
                            n_state          = ST_RET;
                        end
                    end
                    lrat_pkg::KIND_ADD: begin
                        if (disjoint) begin
                            n_state = ST_RET;
                        end else if (covered) begin
                            o_we    = 1'b1;
                            o_waddr = r_node;
                            o_wdata = lrat_pkg::give(i_rdata, r_v, !is_leaf);
                            n_state = ST_RET;
                        end
                    end
                    lrat_pkg::KIND_MAX: begin
                        if (disjoint) begin
                            n_state = ST_RET;
                        end else if (covered) begin
                            n_acc   = lrat_pkg::smax(r_acc, i_rdata.node_max);
                            n_state = ST_RET;
                        end
                    end
                    default: begin
                        if (r_node == AW'(1) && i_rdata.node_max < 64'sd0) begin
                            n_res   = lrat_pkg::NONE;
                            n_state = ST_OUT;
                        end else if (is_leaf) begin
                            n_res   = (i_rdata.node_max >= 64'sd0) ? 64'(r_nlo)
                                                                   : lrat_pkg::NONE;
                            n_state = ST_OUT;
                        end
                    end
                endcase
            end
            ST_PB: begin
                o_we    = 1'b1;
                o_waddr = left_c;
                o_wdata = lrat_pkg::give(i_rdata, r_tag, kids_int);
                o_raddr = right_c;
                n_state = ST_PC;
            end
            ST_PC: begin
                o_we    = 1'b1;
                o_waddr = right_c;
                o_wdata = lrat_pkg::give(i_rdata, r_tag, kids_int);
                n_state = ST_PD;
            end
            ST_PD: begin
                o_we    = 1'b1;
                o_waddr = r_node;
                o_wdata = self_e;
                n_state = ST_DESC;
            end
            ST_DESC: begin
                n_sz    = half;
                n_state = ST_VISIT;
                if (r_kind == lrat_pkg::KIND_SEARCH) begin
                    o_raddr = right_c;
                    n_sz    = r_sz;
                    n_state = ST_SRCH;
                end else if (r_kind == lrat_pkg::KIND_SET && r_lo >= r_nlo + half) begin
                    n_node = right_c;
                    n_nlo  = r_nlo + half;
                end else begin
                    n_node = left_c;
                end
            end
            ST_SRCH: begin
                n_sz    = half;
                n_state = ST_VISIT;
                if (i_rdata.node_max >= 64'sd0) begin
                    n_node = right_c;
                    n_nlo  = r_nlo + half;
                end else begin
                    n_node = left_c;
                end
            end
            ST_RET: begin
                if (r_node == AW'(1)) begin
                    if (r_kind == lrat_pkg::KIND_MAX) begin
                        n_res   = r_acc;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (r_kind != lrat_pkg::KIND_SET && !r_node[0]) begin
                    n_node  = r_node + AW'(1);
                    n_nlo   = r_nlo + r_sz;
                    n_state = ST_VISIT;
                end else begin
                    n_node  = r_node >> 1;
                    n_sz    = r_sz << 1;
                    n_nlo   = r_node[0] ? r_nlo - r_sz : r_nlo;
                    o_raddr = {r_node[AW-1:1], 1'b0};
                    n_state = (r_kind == lrat_pkg::KIND_MAX) ? ST_RET : ST_RB1;
                end
            end
            ST_RB1: begin
                n_left  = i_rdata.node_max;
                o_raddr = right_c;
                n_state = ST_RB2;
            end
            ST_RB2: begin
                o_we    = 1'b1;
                o_waddr = r_node;
                o_wdata = rb_e;
                n_state = ST_RET;
            end
            ST_OUT: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_kind <= n_kind;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_v    <= n_v;
        r_node <= n_node;
        r_nlo  <= n_nlo;
        r_sz   <= n_sz;
        r_tag  <= n_tag;
        r_self <= n_self;
        r_left <= n_left;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_OUT);
    assign o_res       = r_res;

endmodule

[rtl/lazy_range_add_max_tree.sv]
// ----------------------------------------------------------------------------
// lazy_range_add_max_tree
// Range-add / range-max tree with lazy tags kept in one node memory.
//
//   channel   direction   handshake           payload
//   input     in          i_valid / o_ready   i_kind, i_range_low,
//                                             i_range_high, i_operand_value
//   result    out         o_valid / i_ready   o_answer
//
// After reset a clearing pass writes all 2*LEAVES (rounded up to a power of
// two) node entries, one per cycle, with the input held off.
// An item walks the tree; each node visited, each tag push and each parent
// rebuild takes its own states, set by the single read and single write port
// of the node memory. An item that leaves the tree alone does not walk it.
// The result register frees the walk: a waiting result stalls only the next
// item that produces one.
// ----------------------------------------------------------------------------
module lazy_range_add_max_tree #(
    parameter int LEAVES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [9:0]         i_range_low,
    input  logic [10:0]        i_range_high,
    input  logic signed [63:0] i_operand_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_answer
);

    localparam int AW = $clog2(LEAVES) + 1;

    logic               res_valid, res_ready;
    logic signed [63:0] res;
    logic               we;
    logic [AW-1:0]      waddr, raddr;
    lrat_pkg::t_entry   wdata, rdata;
    logic               r_ovalid;
    logic signed [63:0] r_answer;

    lrat_seq #(.LEAVES(LEAVES)) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .i_operand_value (i_operand_value),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .i_res_ready     (res_ready),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_raddr         (raddr),
        .i_rdata         (rdata)
    );

    lrat_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign res_ready = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_answer <= res;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_answer = r_answer;

endmodule

[rtl/lrat_checker.sv]
// ----------------------------------------------------------------------------
// lrat_checker
// Port-level checks for the lazy range-add / range-max tree.
// ----------------------------------------------------------------------------
module lrat_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [1:0]         i_kind,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [63:0] o_answer
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_answer))
        else $error("result dropped or changed while stalled");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_kind == lrat_pkg::KIND_MAX || i_kind == lrat_pkg::KIND_SEARCH)
        |=> !o_ready)
        else $error("input still ready right after a transfer");

    a_set_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind == lrat_pkg::KIND_SET && !o_valid |=> !o_valid)
        else $error("leaf write produced a result");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("ports active during reset or clearing");

endmodule

bind lazy_range_add_max_tree lrat_checker u_lrat_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_kind   (i_kind),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_answer (o_answer)
);
